// ===== sv/assert_macros.svh =====
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked on every clock edge outside reset.
`define ASSERT_RST(label, clk, rstn, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Property checked on every clock edge, reset included.
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

// ===== sv/mfnv_pkg.sv =====
// Types, constants and helper functions of the multi-seed FNV-1a hasher.
package mfnv_pkg;

    localparam logic [31:0] FNV_BASIS  = 32'd2166136261;
    localparam logic [31:0] FNV_PRIME  = 32'd16777619;
    localparam int          WORD_COUNT = 8;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } in_t;

    typedef struct packed {
        logic [31:0] digest_word0;
        logic [31:0] digest_word1;
        logic [31:0] digest_word2;
        logic [31:0] digest_word3;
        logic [31:0] digest_word4;
        logic [31:0] digest_word5;
        logic [31:0] digest_word6;
        logic [31:0] digest_word7;
    } out_t;

    typedef struct packed {
        logic step;
        logic reseed;
    } lane_ctrl_t;

    // Seed of lane h: basis + h * prime, mod 2^32.
    function automatic logic [31:0] seed_of(input int unsigned h);
        logic [63:0] sum;
        sum = 64'(FNV_BASIS) + 64'(h) * 64'(FNV_PRIME);
        return sum[31:0];
    endfunction

    // One FNV-1a round: xor the byte in, multiply by the prime, mod 2^32.
    function automatic logic [31:0] fnv_step(input logic [31:0] hash, input logic [7:0] b);
        logic [31:0] x;
        x = hash ^ {24'd0, b};
        return x * FNV_PRIME;
    endfunction

endpackage

// ===== sv/mfnv_lane.sv =====
// One FNV-1a hash lane: running state register and its per-byte update.
module mfnv_lane #(
    parameter logic [31:0] SEED = 32'd2166136261
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  mfnv_pkg::lane_ctrl_t ctrl,
    input  logic [7:0]           in_byte,
    output logic [31:0]          hash_new
);

    logic [31:0] hash_reg;
    logic [31:0] hash_next;

    assign hash_new = mfnv_pkg::fnv_step(hash_reg, in_byte);

    always_comb begin
        hash_next = hash_reg;
        if (ctrl.step) begin
            hash_next = ctrl.reseed ? SEED : hash_new;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hash_reg <= SEED;
        end else begin
            hash_reg <= hash_next;
        end
    end

endmodule

// ===== sv/multi_seed_fnv1a_hash.sv =====
// Top level of the multi-seed FNV-1a hasher: input register, lanes, digest register.
// A final byte passes from the input register into the digest register, whose valid bit drives m_valid.
// Throughput: one byte per cycle while no final byte waits on a full digest register; one constant multiply per lane.
// A stalled digest holds one message byte in the input register before s_ready drops.
// Reset (aresetn low, synchronous): both registers empty, every lane back at its seed.
module multi_seed_fnv1a_hash #(
    parameter int HASH_LANES = 8
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_valid,
    output logic           s_ready,
    input  mfnv_pkg::in_t  s_payload,
    output logic           m_valid,
    input  logic           m_ready,
    output mfnv_pkg::out_t m_payload
);

    localparam int ActiveLanes =
        (HASH_LANES < mfnv_pkg::WORD_COUNT) ? HASH_LANES : mfnv_pkg::WORD_COUNT;

    // Input register: one byte transaction waiting for the lanes.
    mfnv_pkg::in_t  in_reg;
    logic           in_valid_reg;
    logic           in_valid_next;

    // Digest register: one result transaction waiting for the sink.
    mfnv_pkg::out_t out_reg;
    mfnv_pkg::out_t out_next;
    logic           out_valid_reg;
    logic           out_valid_next;

    logic                 out_free;
    logic                 advance;
    logic                 s_take;
    mfnv_pkg::lane_ctrl_t lane_ctrl;
    logic [31:0]          lane_word [mfnv_pkg::WORD_COUNT];

    // The digest slot is free when empty or drained this cycle. An ordinary byte
    // never needs it, so only a final byte can stall in the input register.
    assign out_free = !out_valid_reg || m_ready;
    assign advance  = in_valid_reg && (!in_reg.last_byte || out_free);
    assign s_ready  = !in_valid_reg || advance;
    assign s_take   = s_valid && s_ready;

    assign lane_ctrl.step   = advance;
    assign lane_ctrl.reseed = in_reg.last_byte;

    // Lanes: those beyond the lane count report zero.
    for (genvar h = 0; h < mfnv_pkg::WORD_COUNT; h++) begin : g_lane
        if (h < ActiveLanes) begin : g_on
            mfnv_lane #(
                .SEED(mfnv_pkg::seed_of(h))
            ) u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .ctrl    (lane_ctrl),
                .in_byte (in_reg.data_byte),
                .hash_new(lane_word[h])
            );
        end else begin : g_off
            assign lane_word[h] = '0;
        end
    end

    assign in_valid_next = s_take || (in_valid_reg && !advance);

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg && !m_ready;
        if (advance && in_reg.last_byte) begin
            out_valid_next         = 1'b1;
            out_next.digest_word0  = lane_word[0];
            out_next.digest_word1  = lane_word[1];
            out_next.digest_word2  = lane_word[2];
            out_next.digest_word3  = lane_word[3];
            out_next.digest_word4  = lane_word[4];
            out_next.digest_word5  = lane_word[5];
            out_next.digest_word6  = lane_word[6];
            out_next.digest_word7  = lane_word[7];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers, no reset needed.
    always_ff @(posedge aclk) begin
        if (s_take) begin
            in_reg <= s_payload;
        end
        out_reg <= out_next;
    end

    assign m_valid   = out_valid_reg;
    assign m_payload = out_reg;

endmodule

// ===== sv/mfnv_checker.sv =====
// Port-level checker for the multi-seed FNV-1a hasher, with its bind.
`include "assert_macros.svh"

module mfnv_checker (
    input logic           aclk,
    input logic           aresetn,
    input logic           s_valid,
    input logic           s_ready,
    input mfnv_pkg::in_t  s_payload,
    input logic           m_valid,
    input logic           m_ready,
    input mfnv_pkg::out_t m_payload
);

    `ASSERT_RST(a_m_valid_hold, aclk, aresetn, m_valid && !m_ready |=> m_valid, "digest dropped while stalled")
    `ASSERT_RST(a_m_payload_hold, aclk, aresetn, m_valid && !m_ready |=> $stable(m_payload), "digest changed while stalled")
    `ASSERT_RST(a_ready_when_empty, aclk, aresetn, !m_valid |-> s_ready, "input stalled with empty digest slot")
    `ASSERT_ALWAYS(a_reset_clears, aclk, !aresetn |=> !m_valid, "digest valid after reset")

endmodule

bind multi_seed_fnv1a_hash mfnv_checker u_mfnv_checker (.*);

// ===== tb/tb_multi_seed_fnv1a_hash.sv =====
// Testbench for the multi-seed FNV-1a hasher: random byte streams checked against a lane model.
module tb_multi_seed_fnv1a_hash;
    import mfnv_pkg::*;

    // Lane count of the build under test; the model zeroes the words of absent lanes.
    localparam int LANES = 8;
    // About this many message bytes in total.
    localparam int BYTE_TARGET = 1150;
    // Generous bound: every byte behind a long sender gap plus a long digest stall.
    localparam int TIMEOUT_CYCLES = 400000;
    localparam int CLK_HALF = 10;

    // Receiver behavior, picked anew at random whenever the current mode runs out.
    typedef enum int {
        RDY_ALWAYS,
        RDY_RANDOM,
        RDY_PERIODIC,
        RDY_STARVED
    } ready_mode_e;

    // Scoreboard: keeps its own lane state, queues the digest of every finished
    // message and compares each digest transaction against the oldest entry.
    class digest_scoreboard;
        int          lane_count;
        logic [31:0] lane_state [WORD_COUNT];
        out_t        expected_digests [$];
        int          mismatches;
        int          digests_checked;

        function new(int lanes);
            lane_count      = (lanes < WORD_COUNT) ? lanes : WORD_COUNT;
            mismatches      = 0;
            digests_checked = 0;
            reseed_lanes();
        endfunction

        // Lane h starts at basis + h * prime; each step adds one more prime.
        function void reseed_lanes();
            logic [31:0] seed;
            seed = FNV_BASIS;
            for (int h = 0; h < WORD_COUNT; h++) begin
                lane_state[h] = seed;
                seed          = seed + FNV_PRIME;
            end
        endfunction

        // Accepted input transaction: fold the byte into every live lane, and
        // on the final byte queue the digest and start over.
        function void absorb_byte(in_t item);
            logic [WORD_COUNT*32-1:0] flat;
            for (int h = 0; h < lane_count; h++)
                lane_state[h] = (lane_state[h] ^ {24'd0, item.data_byte}) * FNV_PRIME;
            if (item.last_byte) begin
                flat = '0;
                // digest_word0 is the most significant word of the packed struct
                for (int h = 0; h < lane_count; h++)
                    flat[(WORD_COUNT-1-h)*32 +: 32] = lane_state[h];
                expected_digests.push_back(out_t'(flat));
                reseed_lanes();
            end
        endfunction

        task report(string msg);
            $display("[%0t] MISMATCH: %s", $time, msg);
            mismatches++;
        endtask

        task check_digest(out_t got);
            out_t                     want;
            logic [WORD_COUNT*32-1:0] got_flat;
            logic [WORD_COUNT*32-1:0] want_flat;
            if (expected_digests.size() == 0) begin
                report($sformatf("digest %08h... with no finished message pending",
                                 got.digest_word0));
                return;
            end
            want = expected_digests.pop_front();
            digests_checked++;
            got_flat  = got;
            want_flat = want;
            for (int h = 0; h < WORD_COUNT; h++)
                if (got_flat[(WORD_COUNT-1-h)*32 +: 32] !== want_flat[(WORD_COUNT-1-h)*32 +: 32])
                    report($sformatf("digest %0d digest_word%0d got %08h want %08h",
                                     digests_checked, h,
                                     got_flat[(WORD_COUNT-1-h)*32 +: 32],
                                     want_flat[(WORD_COUNT-1-h)*32 +: 32]));
        endtask

        function int pending();
            return expected_digests.size();
        endfunction
    endclass

    logic aclk      = 1'b0;
    logic aresetn   = 1'b0;
    logic s_valid   = 1'b0;
    logic s_ready;
    in_t  s_payload = '0;
    logic m_valid;
    logic m_ready   = 1'b0;
    out_t m_payload;

    digest_scoreboard sb = new(LANES);

    int          burst_left    = 0;
    int          bytes_sent    = 0;
    int          messages_sent = 0;
    int          cycle_count   = 0;
    int          mode_left     = 0;
    ready_mode_e ready_mode    = RDY_ALWAYS;

    multi_seed_fnv1a_hash #(
        .HASH_LANES(LANES)
    ) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_valid  (s_valid),
        .s_ready  (s_ready),
        .s_payload(s_payload),
        .m_valid  (m_valid),
        .m_ready  (m_ready),
        .m_payload(m_payload)
    );

    always begin
        #CLK_HALF aclk = 1'b1;
        #CLK_HALF aclk = 1'b0;
    end

    // Both channels are sampled at the rising edge, before this edge's updates land.
    // The digest check runs first; a digest can never belong to a byte taken at the same edge.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready)
                sb.check_digest(m_payload);
            if (s_valid && s_ready)
                sb.absorb_byte(s_payload);
        end
    end

    // Receiver: switches between always ready, coin flips, a fixed duty pattern and
    // long starvation, so stalls hit every phase of the digest path.
    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (mode_left == 0) begin
            ready_mode <= ready_mode_e'($urandom_range(0, 3));
            mode_left  <= $urandom_range(20, 200);
        end else begin
            mode_left <= mode_left - 1;
        end
        case (ready_mode)
            RDY_ALWAYS:   m_ready <= 1'b1;
            RDY_RANDOM:   m_ready <= 1'($urandom_range(0, 1));
            RDY_PERIODIC: m_ready <= (cycle_count % 7) < 4;
            default:      m_ready <= ($urandom_range(0, 15) == 0);
        endcase
    end

    // Sender: bursts of random length, separated by random gaps. Valid stays high
    // between back-to-back transactions of one burst.
    task automatic send_byte(input logic [7:0] b, input logic last);
        in_t item;
        int  gap;
        item.data_byte = b;
        item.last_byte = last;
        if (burst_left == 0) begin
            gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
            // now and then a long burst with no idle cycles at all
            burst_left = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120)
                                                     : $urandom_range(1, 12);
            if (gap > 0) begin
                s_valid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        s_valid   <= 1'b1;
        s_payload <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        burst_left--;
        bytes_sent++;
        if (last)
            messages_sent++;
    endtask

    task automatic send_random_message(input int len);
        for (int i = 0; i < len; i++)
            send_byte(8'($urandom_range(0, 255)), i == len - 1);
    endtask

    initial begin
        int len;
        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: one-byte messages at the byte extremes, then short messages
        // with alternating and single-bit patterns; a message right after a
        // final byte checks the reseed.
        send_byte(8'h00, 1'b1);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h00, 1'b0);
        send_byte(8'hFF, 1'b1);
        send_byte(8'h55, 1'b0);
        send_byte(8'hAA, 1'b0);
        send_byte(8'h01, 1'b0);
        send_byte(8'h80, 1'b0);
        send_byte(8'hFE, 1'b0);
        send_byte(8'h7F, 1'b1);
        send_byte(8'h61, 1'b1);
        send_byte(8'h61, 1'b1);
        for (int i = 0; i < 8; i++)
            send_byte(8'(1 << i), i == 7);

        // Random: mostly short messages, some single bytes, a few long ones.
        while (bytes_sent < BYTE_TARGET) begin
            case ($urandom_range(0, 9))
                0:       len = 1;
                1:       len = $urandom_range(40, 90);
                default: len = $urandom_range(2, 12);
            endcase
            send_random_message(len);
        end
        s_valid <= 1'b0;

        // wait for one digest per finished message, however long the sink stalls
        while (sb.digests_checked < messages_sent) @(posedge aclk);
        // then idle edges to catch any stray extra digest
        repeat (8) @(posedge aclk);

        if (sb.digests_checked != messages_sent || sb.pending() != 0)
            sb.report($sformatf("%0d digests checked for %0d messages, %0d pending",
                                sb.digests_checked, messages_sent, sb.pending()));

        $display("Covered %0d bytes in %0d messages, %0d digests of %0d lanes checked.",
                 bytes_sent, messages_sent, sb.digests_checked, LANES);
        $display("Mismatches: %0d", sb.mismatches);
        if (sb.mismatches == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    initial begin
        #(TIMEOUT_CYCLES * 2 * CLK_HALF);
        $display("Timeout with %0d digests still outstanding", sb.pending());
        $display("simulation failed");
        $finish;
    end

endmodule
